### design/tcq_pkg.sv
// ----------------------------------------------------------------------------
// tcq_pkg
// Shared codes, widths and control structures of the tagged command queue.
// ----------------------------------------------------------------------------
package tcq_pkg;

	localparam int QUEUE_SLOTS_DEF = 32;

	localparam int IN_TDATA_W  = 96;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 8;
	localparam int OUT_TUSER_W = 1;
	localparam int SLOT_DATA_W = 22;

	localparam logic [2:0] REQ_ADD_ORDERED = 3'd0;
	localparam logic [2:0] REQ_ADD_TAIL    = 3'd1;
	localparam logic [2:0] REQ_REMOVE_HEAD = 3'd2;
	localparam logic [2:0] REQ_NOT_BUSY    = 3'd3;
	localparam logic [2:0] REQ_BY_TAG      = 3'd4;
	localparam logic [2:0] REQ_PROBE       = 3'd5;
	localparam logic [2:0] REQ_CONTAINS    = 3'd6;
	localparam logic [2:0] REQ_REM_HANDLE  = 3'd7;

	localparam logic [7:0] REQ_SENSE_OPCODE = 8'h03;

	typedef logic [3:0] cmd_t;

	localparam cmd_t CMD_NONE     = 4'd0;
	localparam cmd_t CMD_LOAD     = 4'd1;
	localparam cmd_t CMD_ALLOC_RD = 4'd2;
	localparam cmd_t CMD_ADD      = 4'd3;
	localparam cmd_t CMD_LINK     = 4'd4;
	localparam cmd_t CMD_RD       = 4'd5;
	localparam cmd_t CMD_STEP     = 4'd6;
	localparam cmd_t CMD_UNLINK   = 4'd7;
	localparam cmd_t CMD_FREE     = 4'd8;
	localparam cmd_t CMD_MARK     = 4'd9;
	localparam cmd_t CMD_EMIT     = 4'd10;

	typedef struct packed {
		logic is_add;
		logic pool_full;
		logic stack_empty;
		logic list_empty;
		logic add_link;
		logic keep_entry;
		logic match;
		logic next_nil;
		logic out_busy;
	} tcq_stat_t;

endpackage

### design/tcq_dp.sv
// ----------------------------------------------------------------------------
// tcq_dp
// Slot pool, link memory, list pointers, free stack and result registers.
// ----------------------------------------------------------------------------
module tcq_dp import tcq_pkg::*; #(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_accept,
	input  logic [IN_TDATA_W-1:0]  in_data,
	input  logic [IN_TUSER_W-1:0]  in_kind,
	input  cmd_t                   cmd,
	output tcq_stat_t              stat,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data,
	output logic [OUT_TUSER_W-1:0] out_flag
);

	localparam int AW = $clog2(QUEUE_SLOTS);
	localparam int IW = $clog2(QUEUE_SLOTS + 1);
	localparam logic [IW-1:0] NIL = IW'(QUEUE_SLOTS);

	logic [2:0]  kind_q;
	logic [7:0]  handle_q, opc_q, tag_q;
	logic [2:0]  tgt_q, lun_q;
	logic [63:0] mask_q;

	logic [IW-1:0] next_mem [QUEUE_SLOTS];
	logic [SLOT_DATA_W-1:0] data_mem [QUEUE_SLOTS];
	logic [IW-1:0] rd_next_q;
	logic [SLOT_DATA_W-1:0] rd_data_q;

	logic [IW-1:0] head_q, tail_q, stack_q, fresh_q, cur_q, prev_q;
	logic          res_ok_q;
	logic [7:0]    res_h_q;
	logic          out_valid_q, out_ok_q;
	logic [7:0]    out_h_q;

	logic [IW-1:0] alloc_s, rd_addr, wr_addr, wr_val;
	logic          rd_en, wr_en, sense;
	logic [5:0]    unit;

	// request capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q   <= in_kind;
			handle_q <= in_data[7:0];
			opc_q    <= in_data[15:8];
			tgt_q    <= in_data[18:16];
			lun_q    <= in_data[21:19];
			tag_q    <= in_data[29:22];
			mask_q   <= in_data[93:30];
		end
	end

	// slot word: handle[7:0], lun[10:8], target[13:11], tag[21:14]
	assign alloc_s = (stack_q == NIL) ? fresh_q : stack_q;
	assign sense   = (kind_q == REQ_ADD_ORDERED) && (opc_q == REQ_SENSE_OPCODE);
	assign unit    = {rd_data_q[13:11], rd_data_q[10:8]};

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q;
		unique case (cmd)
			CMD_RD: rd_en = 1'b1;
			CMD_ALLOC_RD: begin
				rd_en   = 1'b1;
				rd_addr = stack_q;
			end
			CMD_STEP: begin
				rd_en   = 1'b1;
				rd_addr = rd_next_q;
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_val  = NIL;
		unique case (cmd)
			CMD_ADD: begin
				wr_en   = 1'b1;
				wr_addr = alloc_s;
				wr_val  = (head_q != NIL && sense) ? head_q : NIL;
			end
			CMD_LINK: begin
				wr_en   = 1'b1;
				wr_addr = prev_q;
				wr_val  = cur_q;
			end
			CMD_UNLINK: begin
				wr_en   = (prev_q != NIL);
				wr_addr = prev_q;
				wr_val  = rd_next_q;
			end
			CMD_FREE: begin
				wr_en   = 1'b1;
				wr_addr = cur_q;
				wr_val  = stack_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) next_mem[wr_addr[AW-1:0]] <= wr_val;
		if (cmd == CMD_ADD)
			data_mem[alloc_s[AW-1:0]] <= {tag_q, tgt_q, lun_q, handle_q};
		if (rd_en) begin
			rd_next_q <= next_mem[rd_addr[AW-1:0]];
			rd_data_q <= data_mem[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= NIL;
			tail_q      <= NIL;
			stack_q     <= NIL;
			fresh_q     <= '0;
			cur_q       <= NIL;
			prev_q      <= NIL;
			res_ok_q    <= 1'b0;
			res_h_q     <= '0;
			out_valid_q <= 1'b0;
			out_ok_q    <= 1'b0;
			out_h_q     <= '0;
		end else begin
			unique case (cmd)
				CMD_LOAD: begin
					cur_q    <= head_q;
					prev_q   <= NIL;
					res_ok_q <= 1'b0;
					res_h_q  <= '0;
				end
				CMD_ADD: begin
					if (stack_q != NIL) stack_q <= rd_next_q;
					else fresh_q <= fresh_q + 1'b1;
					cur_q    <= alloc_s;
					res_ok_q <= 1'b1;
					if (head_q == NIL) begin
						head_q <= alloc_s;
						tail_q <= alloc_s;
					end else if (sense) begin
						head_q <= alloc_s;
					end else begin
						prev_q <= tail_q;
						tail_q <= alloc_s;
					end
				end
				CMD_STEP: begin
					prev_q <= cur_q;
					cur_q  <= rd_next_q;
				end
				CMD_UNLINK: begin
					res_ok_q <= 1'b1;
					res_h_q  <= rd_data_q[7:0];
					if (prev_q == NIL) head_q <= rd_next_q;
					if (rd_next_q == NIL) tail_q <= prev_q;
				end
				CMD_FREE: stack_q  <= cur_q;
				CMD_MARK: res_ok_q <= 1'b1;
				default: ;
			endcase
			if (cmd == CMD_EMIT) begin
				out_valid_q <= 1'b1;
				out_ok_q    <= res_ok_q;
				out_h_q     <= res_h_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.is_add      = (kind_q == REQ_ADD_ORDERED) || (kind_q == REQ_ADD_TAIL);
		stat.stack_empty = (stack_q == NIL);
		stat.pool_full   = (stack_q == NIL) && (fresh_q == NIL);
		stat.list_empty  = (head_q == NIL);
		stat.add_link    = (head_q != NIL) && !sense;
		stat.keep_entry  = (kind_q == REQ_PROBE) || (kind_q == REQ_CONTAINS);
		stat.next_nil    = (rd_next_q == NIL);
		stat.out_busy    = out_valid_q && !out_ready;
		unique case (kind_q)
			REQ_REMOVE_HEAD: stat.match = 1'b1;
			REQ_NOT_BUSY:    stat.match = !mask_q[unit];
			REQ_BY_TAG:      stat.match = (rd_data_q[13:11] == tgt_q) &&
			                              (rd_data_q[10:8] == lun_q) &&
			                              (rd_data_q[21:14] == tag_q);
			REQ_PROBE:       stat.match = (rd_data_q[13:11] == tgt_q) &&
			                              (rd_data_q[10:8] == lun_q);
			default:         stat.match = (rd_data_q[7:0] == handle_q);
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_h_q;
	assign out_flag  = out_ok_q;

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NIL) == (tail_q == NIL)) else $error("head and tail disagree on empty");
	a_add_links: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_ADD) |=> (head_q != NIL) && res_ok_q) else $error("add left list empty");
	a_free_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_FREE) |=> (stack_q == $past(cur_q))) else $error("free stack not pushed");
	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NIL) else $error("fresh count past pool");

endmodule

### design/tcq_ctrl.sv
// ----------------------------------------------------------------------------
// tcq_ctrl
// Sequencer of the queue operations: dispatch, allocate, walk, unlink, emit.
// ----------------------------------------------------------------------------
module tcq_ctrl import tcq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_accept,
	output logic      in_ready,
	input  tcq_stat_t stat,
	output cmd_t      cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_LINK = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;
	localparam logic [2:0] S_FREE = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_IDLE: if (in_accept) begin
				cmd     = CMD_LOAD;
				state_d = S_DISP;
			end
			S_DISP: begin
				if (stat.is_add) begin
					if (stat.pool_full) begin
						state_d = S_OUT;
					end else begin
						if (!stat.stack_empty) cmd = CMD_ALLOC_RD;
						state_d = S_ADD;
					end
				end else if (stat.list_empty) begin
					state_d = S_OUT;
				end else begin
					cmd     = CMD_RD;
					state_d = S_CHK;
				end
			end
			S_ADD: begin
				cmd     = CMD_ADD;
				state_d = stat.add_link ? S_LINK : S_OUT;
			end
			S_LINK: begin
				cmd     = CMD_LINK;
				state_d = S_OUT;
			end
			S_CHK: begin
				priority if (stat.match && stat.keep_entry) begin
					cmd     = CMD_MARK;
					state_d = S_OUT;
				end else if (stat.match) begin
					cmd     = CMD_UNLINK;
					state_d = S_FREE;
				end else if (stat.next_nil) begin
					state_d = S_OUT;
				end else begin
					cmd = CMD_STEP;
				end
			end
			S_FREE: begin
				cmd     = CMD_FREE;
				state_d = S_OUT;
			end
			S_OUT: if (!stat.out_busy) begin
				cmd     = CMD_EMIT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

### design/tagged_command_queue_core.sv
// ----------------------------------------------------------------------------
// tagged_command_queue_core
// Linked-list queue of pending disk commands over a fixed pool of slots.
// ----------------------------------------------------------------------------
// Steps: an add passes dispatch and allocate, then a link step when it goes
//   behind the tail; a full pool goes straight to the result. Other requests
//   read and check the slots along the walk, then free an unlinked entry.
// Throughput: one item at a time, next accepted in the cycle after the result
//   is launched, later while a stalled sink holds the result register.
// Reset: queue empty, all slots free; no clearing pass is needed.
module tagged_command_queue_core import tcq_pkg::*; #(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// cmd_handle[7:0], opcode[15:8], target[18:16], lun[21:19], tag[29:22],
	// busy_mask[93:30], zero[95:94]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// req_type[2:0]
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_handle[7:0]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// ok[0]
	output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	logic      in_accept;
	tcq_stat_t stat;
	cmd_t      cmd;

	assign in_accept = s_axis_tvalid && s_axis_tready;

	tcq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_ready  (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcq_dp #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_data   (s_axis_tdata),
		.in_kind   (s_axis_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_flag  (m_axis_tuser)
	);

endmodule

### sim/tagged_command_queue_core_tb.sv
// ----------------------------------------------------------------------------
// tagged_command_queue_core_tb
// Drives request items into the command queue with random gaps and stalls,
// predicts ok and the removed handle from a model of the linked slot pool,
// and checks each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module tagged_command_queue_core_tb;
	import tcq_pkg::*;

	localparam int SLOTS = QUEUE_SLOTS_DEF;
	localparam int NIL = SLOTS;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 800;

	typedef struct {
		logic [2:0]  req;
		logic [7:0]  handle;
		logic [7:0]  opcode;
		logic [2:0]  target;
		logic [2:0]  lun;
		logic [7:0]  tag;
		logic [63:0] busy;
		bit          fixed;
		logic        ok_x;
		logic [7:0]  handle_x;
	} req_item_t;

	typedef struct {
		logic       ok;
		logic [7:0] handle;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;

	logic [7:0] pool_handle [SLOTS];
	logic [2:0] pool_target [SLOTS];
	logic [2:0] pool_lun [SLOTS];
	logic [7:0] pool_tag [SLOTS];
	int pool_next [SLOTS];
	int pool_prev [SLOTS];
	int q_head, q_tail, free_head;

	outcome_t pending_results[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int sink_wait = 0;
	bit timed_out = 1'b0;
	bit feeding_done = 1'b0;

	tagged_command_queue_core dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [7:0] release_slot(int s, int p);
		int nx;
		nx = pool_next[s];
		if (p == NIL) begin
			q_head = nx;
			if (q_head != NIL) pool_prev[q_head] = NIL;
			else q_tail = NIL;
		end else begin
			pool_next[p] = nx;
			if (nx != NIL) pool_prev[nx] = p;
			else q_tail = p;
		end
		pool_next[s] = free_head;
		pool_prev[s] = NIL;
		free_head = s;
		return pool_handle[s];
	endfunction

	function automatic outcome_t queue_outcome(req_item_t it);
		outcome_t r;
		int s, p, n;
		bit hit;
		r.ok = 1'b0;
		r.handle = 8'd0;
		if (it.req == REQ_ADD_ORDERED || it.req == REQ_ADD_TAIL) begin
			s = free_head;
			if (s != NIL) begin
				free_head = pool_next[s];
				pool_handle[s] = it.handle;
				pool_target[s] = it.target;
				pool_lun[s] = it.lun;
				pool_tag[s] = it.tag;
				if (q_head == NIL) begin
					pool_next[s] = NIL;
					pool_prev[s] = NIL;
					q_head = s;
					q_tail = s;
				end else if (it.req == REQ_ADD_ORDERED && it.opcode == REQ_SENSE_OPCODE) begin
					pool_prev[s] = NIL;
					pool_next[s] = q_head;
					pool_prev[q_head] = s;
					q_head = s;
				end else begin
					pool_next[s] = NIL;
					pool_prev[s] = q_tail;
					pool_next[q_tail] = s;
					q_tail = s;
				end
				r.ok = 1'b1;
			end
		end else if (it.req == REQ_REMOVE_HEAD) begin
			if (q_head != NIL) begin
				r.handle = release_slot(q_head, NIL);
				r.ok = 1'b1;
			end
		end else begin
			s = q_head;
			p = NIL;
			hit = 1'b0;
			for (n = 0; n < SLOTS && s != NIL; n++) begin
				case (it.req)
					REQ_NOT_BUSY: hit = !it.busy[{pool_target[s], pool_lun[s]}];
					REQ_BY_TAG: hit = pool_target[s] == it.target &&
						pool_lun[s] == it.lun && pool_tag[s] == it.tag;
					REQ_PROBE: hit = pool_target[s] == it.target && pool_lun[s] == it.lun;
					default: hit = pool_handle[s] == it.handle;
				endcase
				if (hit) break;
				p = s;
				s = pool_next[s];
			end
			if (hit) begin
				r.ok = 1'b1;
				if (it.req == REQ_NOT_BUSY || it.req == REQ_BY_TAG || it.req == REQ_REM_HANDLE)
					r.handle = release_slot(s, p);
			end
		end
		return r;
	endfunction

	function automatic req_item_t make_req(logic [2:0] rq, logic [7:0] h, logic [7:0] op,
			logic [2:0] t, logic [2:0] l, logic [7:0] tg, logic [63:0] b);
		req_item_t it;
		it.req = rq; it.handle = h; it.opcode = op; it.target = t; it.lun = l;
		it.tag = tg; it.busy = b; it.fixed = 1'b0; it.ok_x = 1'b0; it.handle_x = 8'd0;
		return it;
	endfunction

	function automatic req_item_t with_result(req_item_t it, logic ok, logic [7:0] h);
		it.fixed = 1'b1; it.ok_x = ok; it.handle_x = h;
		return it;
	endfunction

	task automatic send_req(req_item_t it);
		outcome_t r;
		outcome_t x;
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.req;
		s_axis_tdata <= {2'b00, it.busy, it.tag, it.lun, it.target, it.opcode, it.handle};
		do @(posedge clk); while (!s_axis_tready);
		r = queue_outcome(it);
		if (it.fixed) begin
			if (r.ok !== it.ok_x || r.handle !== it.handle_x) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row disagrees with prediction: req %0d", it.req);
			end
			x.ok = it.ok_x;
			x.handle = it.handle_x;
			pending_results.push_back(x);
		end else begin
			pending_results.push_back(r);
		end
	endtask

	// sink waits a drawn number of cycles per item
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sink_wait = $urandom_range(0, 16);
				m_axis_tready <= (sink_wait == 0);
			end else if (m_axis_tvalid && !m_axis_tready) begin
				if (sink_wait > 0) sink_wait--;
				if (sink_wait == 0) m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result ok=%0b handle=%0d",
					m_axis_tuser[0], m_axis_tdata);
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tuser[0] !== e.ok || m_axis_tdata !== e.handle) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected ok=%0b handle=%0d, got ok=%0b handle=%0d",
							e.ok, e.handle, m_axis_tuser[0], m_axis_tdata);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(feeding_done && pending_results.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Regression FAIL");
			$finish;
		end
	end

	req_item_t directed[$];
	req_item_t it;
	logic [7:0] hpool [8];
	logic [63:0] bm;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			pool_handle[i] = '0; pool_target[i] = '0; pool_lun[i] = '0; pool_tag[i] = '0;
			pool_next[i] = i + 1; pool_prev[i] = NIL;
		end
		q_head = NIL; q_tail = NIL; free_head = 0;
		for (int i = 0; i < 8; i++) hpool[i] = 8'($urandom_range(0, 255));

		// empty-queue requests, then extremes, sense-at-head, duplicates, full pool
		directed.push_back(with_result(make_req(REQ_REMOVE_HEAD, 0, 0, 0, 0, 0, 0), 0, 0));
		directed.push_back(with_result(make_req(REQ_NOT_BUSY, 0, 0, 0, 0, 0, 0), 0, 0));
		directed.push_back(with_result(make_req(REQ_BY_TAG, 0, 0, 7, 7, 255, 0), 0, 0));
		directed.push_back(with_result(make_req(REQ_PROBE, 0, 0, 0, 0, 0, 0), 0, 0));
		directed.push_back(with_result(make_req(REQ_CONTAINS, 255, 0, 0, 0, 0, 0), 0, 0));
		directed.push_back(with_result(make_req(REQ_REM_HANDLE, 255, 0, 0, 0, 0, 0), 0, 0));
		directed.push_back(with_result(make_req(REQ_ADD_TAIL, 255, 8'h03, 7, 7, 255, 0), 1, 0));
		directed.push_back(with_result(make_req(REQ_ADD_ORDERED, 0, 8'hFF, 0, 0, 0, 0), 1, 0));
		directed.push_back(with_result(make_req(REQ_ADD_ORDERED, 17, 8'h03, 3, 5, 9, 0), 1, 0));
		directed.push_back(with_result(make_req(REQ_ADD_TAIL, 255, 0, 1, 1, 1, 0), 1, 0));
		directed.push_back(with_result(make_req(REQ_REMOVE_HEAD, 0, 0, 0, 0, 0, 0), 1, 17));
		directed.push_back(with_result(make_req(REQ_PROBE, 0, 0, 7, 7, 0, 0), 1, 0));
		directed.push_back(with_result(make_req(REQ_CONTAINS, 0, 0, 0, 0, 0, 0), 1, 0));
		directed.push_back(with_result(make_req(REQ_NOT_BUSY, 0, 0, 0, 0, 0,
			64'h8000_0000_0000_0000), 1, 0));
		directed.push_back(with_result(make_req(REQ_NOT_BUSY, 0, 0, 0, 0, 0, '1), 0, 0));
		directed.push_back(with_result(make_req(REQ_BY_TAG, 0, 0, 7, 7, 255, 0), 1, 255));
		directed.push_back(with_result(make_req(REQ_REM_HANDLE, 255, 0, 0, 0, 0, 0), 1, 255));
		directed.push_back(with_result(make_req(REQ_REM_HANDLE, 255, 0, 0, 0, 0, 0), 0, 0));
		for (int i = 0; i < SLOTS + 1; i++)
			directed.push_back(make_req(3'($urandom_range(0, 1)), 8'(i),
				$urandom_range(0, 1) ? 8'h03 : 8'hAA, i[2:0], i[5:3], 8'(i), 64'd0));
		directed.push_back(make_req(REQ_NOT_BUSY, 0, 0, 0, 0, 0, 64'h5555_5555_5555_5555));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_req(directed[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			it.req = 3'($urandom_range(0, 7));
			// bias towards adds when empty, removes when the pool is full
			if ($urandom_range(0, 3) == 0)
				it.req = (q_head == NIL || free_head != NIL && $urandom_range(0, 1)) ?
					REQ_ADD_TAIL : REQ_NOT_BUSY;
			it.handle = ($urandom_range(0, 9) < 7) ? hpool[$urandom_range(0, 7)] :
				8'($urandom_range(0, 255));
			it.opcode = ($urandom_range(0, 3) == 0) ? REQ_SENSE_OPCODE :
				8'($urandom_range(0, 255));
			it.target = 3'($urandom_range(0, 7));
			it.lun = 3'($urandom_range(0, 7));
			it.tag = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(0, 3));
			bm = {$urandom, $urandom};
			case ($urandom_range(0, 3))
				0: bm = bm & {$urandom, $urandom};
				1: bm = bm | {$urandom, $urandom};
				default: ;
			endcase
			it.busy = bm;
			it.fixed = 1'b0;
			send_req(it);
		end
		s_axis_tvalid <= 1'b0;

		feeding_done = 1'b1;
		wait (pending_results.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
